// ===== rtl/core/mdq_pkg.sv =====
package mdq_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [0:0] {
        KIND_TICK   = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        REG_QUAD_ENABLE  = 3'd0,
        REG_ALT_PIN_MAP  = 3'd1,
        REG_MOTION_DIV   = 3'd2,
        REG_SPEED_GAIN   = 3'd3,
        REG_SPEED_BASE   = 3'd4,
        REG_SPEED_CAP    = 3'd5
    } reg_idx_t;

    typedef logic [2:0]        button_t;
    typedef logic signed [7:0] motion_t;
    typedef logic [3:0]        pins_t;
    typedef logic [7:0]        count_t;

    localparam logic [6:0] MOTION_DIV_RST = 7'd2;
    localparam logic [7:0] SPEED_GAIN_RST = 8'd4;
    localparam logic [7:0] SPEED_BASE_RST = 8'd8;
    localparam logic [7:0] SPEED_CAP_RST  = 8'd32;
    localparam count_t     COUNT_MAX      = 8'hff;

endpackage

// ===== rtl/core/mdq_if.sv =====
interface mdq_item_if
    import mdq_pkg::*;
();
    logic    valid;
    logic    ready;
    kind_t   kind;
    button_t button_bits;
    motion_t x_motion;
    motion_t y_motion;

    modport source (output valid, kind, button_bits, x_motion, y_motion, input ready);
    modport sink   (input valid, kind, button_bits, x_motion, y_motion, output ready);
endinterface

interface mdq_result_if
    import mdq_pkg::*;
();
    logic    valid;
    logic    ready;
    pins_t   quad_pins;
    button_t button_pins;
    count_t  x_pending;
    count_t  y_pending;

    modport source (output valid, quad_pins, button_pins, x_pending, y_pending, input ready);
    modport sink   (input valid, quad_pins, button_pins, x_pending, y_pending, output ready);
endinterface

// ===== rtl/core/mouse_delta_quadrature_gen_core.sv =====
// Mouse report to two-axis quadrature generator. Every input beat (report or
// timer tick) yields exactly one result beat carrying the pin levels, the
// active-low buttons and both pending pulse counts after that beat. One item
// is worked on at a time; a finished result sits in an output register so the
// next item can be taken while it waits. A report sends each axis in turn
// through load, a bit-serial restoring divider, merge, a shift-add multiplier
// and the step update; an axis with zero motion only goes through load. A tick
// does one accumulator add per axis with pulses pending, or none while
// quadrature output is off. Configuration registers sit on the APB port at
// byte addresses 0x00..0x14.
module mouse_delta_quadrature_gen_core
    import mdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    mdq_item_if.sink          item,
    mdq_result_if.source      result
);

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MERGE,
        ST_MUL,
        ST_STEP,
        ST_TICK,
        ST_DONE
    } state_t;

    state_t      state_reg, state_next;

    logic        qen_reg, qen_next;
    logic        alt_reg, alt_next;
    logic [6:0]  div_reg, div_next;
    logic [7:0]  gain_reg, gain_next;
    logic [7:0]  base_reg, base_next;
    logic [7:0]  cap_reg, cap_next;

    count_t      count_reg [2];
    count_t      count_next [2];
    logic [15:0] step_reg [2];
    logic [15:0] step_next [2];
    logic [15:0] accum_reg [2];
    logic [15:0] accum_next [2];
    logic [7:0]  phase_reg [2];
    logic [7:0]  phase_next [2];
    pins_t       pins_reg, pins_next;
    button_t     buttons_reg, buttons_next;

    logic [7:0]  motion_reg [2];
    logic [7:0]  motion_next [2];
    logic        axis_reg, axis_next;
    logic        neg_reg, neg_next;
    logic [6:0]  rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  mplier_reg, mplier_next;
    logic [15:0] mcand_reg, mcand_next;
    logic [15:0] prod_reg, prod_next;

    logic        rv_reg, rv_next;
    pins_t       out_pins_reg, out_pins_next;
    button_t     out_buttons_reg, out_buttons_next;
    count_t      out_x_reg, out_x_next;
    count_t      out_y_reg, out_y_next;

    logic        cfg_wr;
    logic [6:0]  div_eff;

    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;
    assign div_eff      = (div_reg == 7'd0) ? 7'd1 : div_reg;
    assign item.ready   = (state_reg == ST_IDLE);

    assign result.valid       = rv_reg;
    assign result.quad_pins   = out_pins_reg;
    assign result.button_pins = out_buttons_reg;
    assign result.x_pending   = out_x_reg;
    assign result.y_pending   = out_y_reg;

    always_comb
    begin
        prdata = '0;
        case (reg_idx_t'(paddr[4:2]))
            REG_QUAD_ENABLE: prdata = {{(DATA_W-1){1'b0}}, qen_reg};
            REG_ALT_PIN_MAP: prdata = {{(DATA_W-1){1'b0}}, alt_reg};
            REG_MOTION_DIV:  prdata = {{(DATA_W-7){1'b0}}, div_reg};
            REG_SPEED_GAIN:  prdata = {{(DATA_W-8){1'b0}}, gain_reg};
            REG_SPEED_BASE:  prdata = {{(DATA_W-8){1'b0}}, base_reg};
            REG_SPEED_CAP:   prdata = {{(DATA_W-8){1'b0}}, cap_reg};
            default:         prdata = '0;
        endcase
    end

    always_comb
    begin
        logic [7:0]  m;
        logic [7:0]  cnt;
        logic [7:0]  newcnt;
        logic [7:0]  trial;
        logic [7:0]  diff;
        logic        qbit;
        logic        nneg;
        logic [8:0]  sum9;
        logic [15:0] delta;
        logic [15:0] acc_sum;
        logic        pa;
        logic        pb;

        m       = motion_reg[axis_reg];
        cnt     = count_reg[axis_reg];
        newcnt  = cnt;
        trial   = {rem_reg, quo_reg[7]};
        diff    = trial - {1'b0, div_eff};
        qbit    = (trial >= {1'b0, div_eff});
        nneg    = neg_reg;
        sum9    = {1'b0, cnt} + {1'b0, quo_reg};
        delta   = {8'd0, base_reg} + prod_reg;
        acc_sum = accum_reg[axis_reg] + step_reg[axis_reg];
        pa      = acc_sum[8] ^ acc_sum[9];
        pb      = acc_sum[9];

        state_next       = state_reg;
        qen_next         = qen_reg;
        alt_next         = alt_reg;
        div_next         = div_reg;
        gain_next        = gain_reg;
        base_next        = base_reg;
        cap_next         = cap_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        accum_next       = accum_reg;
        phase_next       = phase_reg;
        pins_next        = pins_reg;
        buttons_next     = buttons_reg;
        motion_next      = motion_reg;
        axis_next        = axis_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        bit_cnt_next     = bit_cnt_reg;
        mplier_next      = mplier_reg;
        mcand_next       = mcand_reg;
        prod_next        = prod_reg;
        rv_next          = rv_reg && !result.ready;
        out_pins_next    = out_pins_reg;
        out_buttons_next = out_buttons_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;

        if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_QUAD_ENABLE: qen_next  = pwdata[0];
                REG_ALT_PIN_MAP: alt_next  = pwdata[0];
                REG_MOTION_DIV:  div_next  = pwdata[6:0];
                REG_SPEED_GAIN:  gain_next = pwdata[7:0];
                REG_SPEED_BASE:  base_next = pwdata[7:0];
                REG_SPEED_CAP:   cap_next  = pwdata[7:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    axis_next = AXIS_X;
                    if (item.kind == KIND_REPORT)
                    begin
                        buttons_next   = ~item.button_bits;
                        motion_next[0] = $unsigned(item.x_motion);
                        motion_next[1] = $unsigned(item.y_motion);
                        state_next     = ST_LOAD;
                    end
                    else if (qen_reg)
                    begin
                        state_next = ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_LOAD:
            begin
                if (m == 8'd0)
                begin
                    if (axis_reg == AXIS_Y)
                        state_next = ST_DONE;
                    else
                        axis_next = AXIS_Y;
                end
                else
                begin
                    neg_next     = m[7];
                    quo_next     = m[7] ? (8'd0 - m) : m;
                    rem_next     = 7'd0;
                    bit_cnt_next = 3'd0;
                    state_next   = ST_DIV;
                end
            end

            // restoring divide, one quotient bit per cycle
            ST_DIV:
            begin
                rem_next     = qbit ? diff[6:0] : trial[6:0];
                quo_next     = {quo_reg[6:0], qbit};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                if (cnt != 8'd0 && neg_reg != step_reg[axis_reg][15])
                begin
                    if (cnt >= quo_reg)
                    begin
                        newcnt = cnt - quo_reg;
                        nneg   = !neg_reg;
                    end
                    else
                    begin
                        newcnt = quo_reg - cnt;
                    end
                end
                else
                begin
                    newcnt = sum9[8] ? COUNT_MAX : sum9[7:0];
                end
                count_next[axis_reg] = newcnt;
                neg_next     = nneg;
                mplier_next  = newcnt;
                mcand_next   = {8'd0, gain_reg};
                prod_next    = 16'd0;
                bit_cnt_next = 3'd0;
                state_next   = ST_MUL;
            end

            // shift-add multiply, one multiplier bit per cycle
            ST_MUL:
            begin
                prod_next    = prod_reg + (mplier_reg[0] ? mcand_reg : 16'd0);
                mplier_next  = {1'b0, mplier_reg[7:1]};
                mcand_next   = {mcand_reg[14:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    state_next = ST_STEP;
            end

            ST_STEP:
            begin
                if (delta >= {8'd0, cap_reg})
                    delta = {8'd0, cap_reg};
                step_next[axis_reg] = neg_reg ? (16'd0 - delta) : delta;
                if (axis_reg == AXIS_Y)
                    state_next = ST_DONE;
                else
                begin
                    axis_next  = AXIS_Y;
                    state_next = ST_LOAD;
                end
            end

            ST_TICK:
            begin
                if (cnt == 8'd0)
                begin
                    step_next[axis_reg] = 16'd0;
                end
                else
                begin
                    accum_next[axis_reg] = acc_sum;
                    if (acc_sum[15:8] != phase_reg[axis_reg])
                    begin
                        phase_next[axis_reg] = acc_sum[15:8];
                        count_next[axis_reg] = cnt - 8'd1;
                        if (axis_reg == AXIS_X)
                        begin
                            pins_next[1] = pa;
                            if (alt_reg)
                                pins_next[3] = pb;
                            else
                                pins_next[0] = pb;
                        end
                        else if (alt_reg)
                        begin
                            pins_next[0] = pa;
                            pins_next[2] = pb;
                        end
                        else
                        begin
                            pins_next[3] = pa;
                            pins_next[2] = pb;
                        end
                    end
                end
                if (axis_reg == AXIS_Y)
                    state_next = ST_DONE;
                else
                    axis_next = AXIS_Y;
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!rv_reg || result.ready)
                begin
                    rv_next          = 1'b1;
                    out_pins_next    = pins_reg;
                    out_buttons_next = buttons_reg;
                    out_x_next       = count_reg[0];
                    out_y_next       = count_reg[1];
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            qen_reg         <= 1'b0;
            alt_reg         <= 1'b0;
            div_reg         <= MOTION_DIV_RST;
            gain_reg        <= SPEED_GAIN_RST;
            base_reg        <= SPEED_BASE_RST;
            cap_reg         <= SPEED_CAP_RST;
            count_reg       <= '{default: '0};
            step_reg        <= '{default: '0};
            accum_reg       <= '{default: '0};
            phase_reg       <= '{default: '0};
            pins_reg        <= '0;
            buttons_reg     <= '1;
            motion_reg      <= '{default: '0};
            axis_reg        <= AXIS_X;
            neg_reg         <= 1'b0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            bit_cnt_reg     <= '0;
            mplier_reg      <= '0;
            mcand_reg       <= '0;
            prod_reg        <= '0;
            rv_reg          <= 1'b0;
            out_pins_reg    <= '0;
            out_buttons_reg <= '1;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            qen_reg         <= qen_next;
            alt_reg         <= alt_next;
            div_reg         <= div_next;
            gain_reg        <= gain_next;
            base_reg        <= base_next;
            cap_reg         <= cap_next;
            count_reg       <= count_next;
            step_reg        <= step_next;
            accum_reg       <= accum_next;
            phase_reg       <= phase_next;
            pins_reg        <= pins_next;
            buttons_reg     <= buttons_next;
            motion_reg      <= motion_next;
            axis_reg        <= axis_next;
            neg_reg         <= neg_next;
            rem_reg         <= rem_next;
            quo_reg         <= quo_next;
            bit_cnt_reg     <= bit_cnt_next;
            mplier_reg      <= mplier_next;
            mcand_reg       <= mcand_next;
            prod_reg        <= prod_next;
            rv_reg          <= rv_next;
            out_pins_reg    <= out_pins_next;
            out_buttons_reg <= out_buttons_next;
            out_x_reg       <= out_x_next;
            out_y_reg       <= out_y_next;
        end
    end

endmodule

// ===== rtl/core/mdq_checker.sv =====
module mdq_checker
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready
);

    logic       item_beat;
    logic       result_beat;
    logic [1:0] outst_reg, outst_next;

    assign item_beat   = item_valid && item_ready;
    assign result_beat = result_valid && result_ready;

    // items taken but not yet delivered
    always_comb
    begin
        outst_next = outst_reg;
        if (item_beat && !result_beat)
            outst_next = outst_reg + 2'd1;
        else if (!item_beat && result_beat)
            outst_next = outst_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outst_reg <= 2'd0;
        else
            outst_reg <= outst_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat |=> !item_ready)
        else $error("item taken while previous item still in work");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_beat |-> outst_reg != 2'd0)
        else $error("result beat with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat |-> outst_reg < 2'd2)
        else $error("more than two items outstanding");

endmodule

bind mouse_delta_quadrature_gen_core mdq_checker u_mdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready)
);
